### rtl/core/swpd_pkg.sv
// Package for the sync-word packet deframer: kind codes, sync bytes,
// result struct and the fixed packet layout tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swpd_pkg;

	localparam logic [1:0] KIND_SWEEP = 2'd0;
	localparam logic [1:0] KIND_PHOTO = 2'd1;
	localparam logic [1:0] KIND_HOUSE = 2'd2;

	localparam logic [7:0] SYNC_SWEEP = 8'hEE;
	localparam logic [7:0] SYNC_PHOTO = 8'hFF;
	localparam logic [7:0] SYNC_HOUSE = 8'hDD;

	localparam logic [4:0] FIELD_SYNC  = 5'd0;
	localparam logic [4:0] FIELD_FIRST = 5'd1;

	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [4:0]  index;
		logic [31:0] value;
		logic        last;
	} swpd_result_t;

	// byte width of a field; 0 marks a position outside the layout
	function automatic logic [2:0] field_width(input logic [1:0] kind, input logic [4:0] fld);
		logic [2:0] w;
		w = 3'd0;
		case (kind)
			KIND_SWEEP: begin
				case (fld)
					5'd0: w = 3'd2;
					5'd1: w = 3'd4;
					5'd2: w = 3'd3;
					5'd3: w = 3'd1;
					5'd4: w = 3'd2;
					5'd5: w = 3'd2;
					default: w = 3'd0;
				endcase
			end
			KIND_PHOTO: begin
				case (fld)
					5'd0: w = 3'd2;
					5'd1: w = 3'd4;
					5'd2: w = 3'd2;
					5'd3: w = 3'd2;
					default: w = 3'd0;
				endcase
			end
			KIND_HOUSE: begin
				if (fld == 5'd1 || fld == 5'd3) begin
					w = 3'd4;
				end else if (fld <= 5'd22) begin
					w = 3'd2;
				end else begin
					w = 3'd0;
				end
			end
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] field_count(input logic [1:0] kind);
		logic [4:0] n;
		case (kind)
			KIND_SWEEP: n = 5'd6;
			KIND_PHOTO: n = 5'd4;
			KIND_HOUSE: n = 5'd23;
			default:    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/core/swpd_in_stage.sv
// Input register stage of the deframer: captures one byte per transfer
// and holds it until the engine takes it. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module swpd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] stream_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic take;

	// held byte blocks the input only when the engine cannot move it on
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= stream_byte;
		end
	end

endmodule

`default_nettype wire

### rtl/core/swpd_engine.sv
// Deframing engine: hunt/packet state registers and the single-pass
// next-state and result logic. Depends on swpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpd_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	output swpd_pkg::swpd_result_t result
);

	import swpd_pkg::*;

	logic [7:0]  held_byte_q, held_byte_d;
	logic        held_valid_q, held_valid_d;
	logic        in_packet_q, in_packet_d;
	logic [1:0]  kind_q, kind_d;
	logic [4:0]  field_q, field_d;
	logic [2:0]  bif_q, bif_d;
	logic [31:0] acc_q, acc_d;

	logic        sync_byte;
	logic [1:0]  sync_kind;
	logic [2:0]  width;
	logic [4:0]  count;
	logic [31:0] acc_shift;
	logic [2:0]  bif_inc;
	logic        is_last;

	always_comb begin
		sync_byte = (byte_in == SYNC_SWEEP) || (byte_in == SYNC_PHOTO) ||
		            (byte_in == SYNC_HOUSE);
		if (byte_in == SYNC_SWEEP) begin
			sync_kind = KIND_SWEEP;
		end else if (byte_in == SYNC_PHOTO) begin
			sync_kind = KIND_PHOTO;
		end else begin
			sync_kind = KIND_HOUSE;
		end
		width     = field_width(kind_q, field_q);
		count     = field_count(kind_q);
		acc_shift = {acc_q[23:0], byte_in};
		bif_inc   = bif_q + 3'd1;
		is_last   = (field_q + 5'd1) == count;
	end

	always_comb begin
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		in_packet_d  = in_packet_q;
		kind_d       = kind_q;
		field_d      = field_q;
		bif_d        = bif_q;
		acc_d        = acc_q;

		result.emit  = 1'b0;
		result.kind  = kind_q;
		result.index = field_q;
		result.value = acc_shift;
		result.last  = 1'b0;

		if (step) begin
			if (!in_packet_q) begin
				if (held_valid_q && held_byte_q == byte_in && sync_byte) begin
					kind_d       = sync_kind;
					in_packet_d  = 1'b1;
					held_valid_d = 1'b0;
					field_d      = FIELD_FIRST;
					bif_d        = 3'd0;
					acc_d        = 32'd0;
					result.emit  = 1'b1;
					result.kind  = sync_kind;
					result.index = FIELD_SYNC;
					result.value = {16'd0, byte_in, byte_in};
				end else begin
					held_byte_d  = byte_in;
					held_valid_d = 1'b1;
				end
			end else if (field_q >= count || width == 3'd0) begin
				// position outside the layout: drop the packet
				in_packet_d  = 1'b0;
				held_valid_d = 1'b0;
				held_byte_d  = 8'd0;
				field_d      = 5'd0;
				bif_d        = 3'd0;
				acc_d        = 32'd0;
			end else begin
				acc_d = acc_shift;
				bif_d = bif_inc;
				if (bif_inc >= width) begin
					result.emit = 1'b1;
					result.last = is_last;
					bif_d       = 3'd0;
					acc_d       = 32'd0;
					if (is_last) begin
						in_packet_d  = 1'b0;
						held_valid_d = 1'b0;
						held_byte_d  = 8'd0;
						field_d      = 5'd0;
					end else begin
						field_d = field_q + 5'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			in_packet_q  <= 1'b0;
			kind_q       <= KIND_SWEEP;
			field_q      <= 5'd0;
			bif_q        <= 3'd0;
			acc_q        <= 32'd0;
		end else begin
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			in_packet_q  <= in_packet_d;
			kind_q       <= kind_d;
			field_q      <= field_d;
			bif_q        <= bif_d;
			acc_q        <= acc_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sync_word_packet_deframer_core.sv
// A byte waits in the input stage; its field (if any) goes to the result register.
// Throughput: one byte per cycle unless the output stalls; one engine pass per byte.
// Reset (arst_n low, asynchronous): hunting with no byte held, no packet, outputs invalid.
// Top level of the sync-word packet deframer; uses swpd_pkg, swpd_in_stage, swpd_engine.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_packet_deframer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  stream_byte,
	// field results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       packet_kind,
	output logic [4:0]       field_index,
	output logic [31:0]      field_value,
	output logic             last_field
);

	import swpd_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	logic         step;
	swpd_result_t result;

	logic         out_valid_q;
	logic [1:0]   kind_q;
	logic [4:0]   index_q;
	logic [31:0]  value_q;
	logic         last_q;

	// The result register may be refilled when it is empty or its transfer
	// completes this cycle; the held byte then goes through the engine.
	assign advance = !out_valid_q || !out_stall;
	assign step    = valid_s1 && advance;

	swpd_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1)
	);

	// Engine state moves only on step, so a stalled output freezes the hunt.
	swpd_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.result  (result)
	);

	// Result register: bytes that complete no field leave it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.emit) begin
			kind_q  <= result.kind;
			index_q <= result.index;
			value_q <= result.value;
			last_q  <= result.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_kind = kind_q;
	assign field_index = index_q;
	assign field_value = value_q;
	assign last_field  = last_q;

	// Sync field carries a doubled byte and never ends a packet.
	a_sync_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_index == FIELD_SYNC |->
			field_value[15:8] == field_value[7:0] && !last_field)
		else $error("sync field malformed");

	// The end flag appears only on each layout's final field.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_field |->
			(packet_kind == KIND_SWEEP && field_index == 5'd5) ||
			(packet_kind == KIND_PHOTO && field_index == 5'd3) ||
			(packet_kind == KIND_HOUSE && field_index == 5'd22))
		else $error("last field flagged at wrong position");

	// The input stalls only while a byte is held and a waiting result is stalled at the output.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without cause");

	// A one-byte field cannot hold more than eight bits.
	a_step_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_kind == KIND_SWEEP && field_index == 5'd3 |->
			field_value[31:8] == 24'd0)
		else $error("step field wider than a byte");

endmodule

`default_nettype wire
